// File: rtl/chash_pkg.sv
// ----------------------------------------------------------------------------
// chash_pkg
// Shared types, sizes and codes for the chained hash table.
// ----------------------------------------------------------------------------
package chash_pkg;

   localparam int BUCKETS  = 32;
   localparam int ENTRIES  = 64;
   localparam int KEY_BITS = 32;
   localparam int VAL_BITS = 32;
   localparam int HASH_MUL = 17;

   localparam int BKT_W = $clog2(BUCKETS);
   localparam int ENT_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);

   localparam logic [CNT_W-1:0] POOL_FULL = CNT_W'(ENTRIES);

   // command and status codes
   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_INSERT = 1'b1;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_HEAD,
      S_LINK,
      S_CMP,
      S_DONE
   } state_type;

   // control from the sequencer to the entry pool
   typedef struct packed {
      logic             entry_we;
      logic [ENT_W-1:0] entry_addr;
      logic             link_we;
      logic [ENT_W-1:0] link_addr;
      logic             link_valid;
      logic [ENT_W-1:0] link_next;
      logic [ENT_W-1:0] rd_addr;
   } pool_ctl_type;

   // registered read word of the entry pool
   typedef struct packed {
      logic [KEY_BITS-1:0] key;
      logic [VAL_BITS-1:0] value;
      logic                next_valid;
      logic [ENT_W-1:0]    next;
   } pool_rd_type;

   // (key * 17) mod BUCKETS; only the low key bits reach the result
   function automatic logic [BKT_W-1:0] hash_bucket(input logic [KEY_BITS-1:0] k);
      logic [2*BKT_W-1:0] prod;
      prod = {{BKT_W{1'b0}}, k[BKT_W-1:0]} * {{BKT_W{1'b0}}, BKT_W'(HASH_MUL)};
      return prod[BKT_W-1:0];
   endfunction

endpackage

// File: rtl/chained_hash_table.sv
// ----------------------------------------------------------------------------
// chained_hash_table
// Hash table with separate chaining over a fixed pool of entries.
// ----------------------------------------------------------------------------
// One word at a time. An insert keeps a tail pointer per bucket so it never
// walks the chain: it passes through S_HEAD, then S_LINK unless its bucket
// was empty, then S_DONE. A lookup compares chain entries until a match or
// the end of the chain:
// the shared key comparator sees one entry a cycle through the registered
// read port of the pool memory. A pool-full insert or a lookup on an empty
// bucket goes from S_HEAD straight to S_DONE. A finished word waits in the
// output register while the next word is accepted. No clearing pass after reset.
// ----------------------------------------------------------------------------
module chained_hash_table (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_cmd,
   input  logic        [chash_pkg::KEY_BITS-1:0] req_key,
   input  logic signed [chash_pkg::VAL_BITS-1:0] req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic        [1:0]                     rsp_status,
   output logic signed [chash_pkg::VAL_BITS-1:0] rsp_found_value,
   output logic        [chash_pkg::CNT_W-1:0]    rsp_entry_count
);

   chash_pkg::state_type state_ff, state_in;

   logic                           cmd_ff, cmd_in;
   logic [chash_pkg::KEY_BITS-1:0] key_ff, key_in;
   logic [chash_pkg::VAL_BITS-1:0] value_ff, value_in;
   logic [chash_pkg::BKT_W-1:0]    bkt_ff, bkt_in;
   logic [chash_pkg::ENT_W-1:0]    head_rd_ff, tail_rd_ff;
   logic [chash_pkg::ENT_W-1:0]    alloc_ff, alloc_in;
   logic [chash_pkg::CNT_W-1:0]    count_ff, count_in;
   logic [chash_pkg::BUCKETS-1:0]  bvalid_ff, bvalid_in;
   logic [1:0]                     status_ff, status_in;
   logic [chash_pkg::VAL_BITS-1:0] found_ff, found_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [1:0]                     rsp_status_ff, rsp_status_in;
   logic [chash_pkg::VAL_BITS-1:0] rsp_found_ff, rsp_found_in;
   logic [chash_pkg::CNT_W-1:0]    rsp_count_ff, rsp_count_in;

   logic [chash_pkg::ENT_W-1:0] head_mem [chash_pkg::BUCKETS];
   logic [chash_pkg::ENT_W-1:0] tail_mem [chash_pkg::BUCKETS];

   chash_pkg::pool_ctl_type pool_ctl;
   chash_pkg::pool_rd_type  pool_rd;

   logic accept;
   logic advance;
   logic head_valid;
   logic full;
   logic key_match;
   logic bkt_we;

   assign accept     = req_valid && req_ready;
   assign advance    = (state_ff == chash_pkg::S_DONE) && (!rsp_valid_ff || rsp_ready);
   assign head_valid = bvalid_ff[bkt_ff];
   assign full       = (count_ff == chash_pkg::POOL_FULL);
   // shared comparator: one chain entry a cycle
   assign key_match  = (pool_rd.key == key_ff);

   chash_pool u_pool (
      .clock    (clock),
      .ctl      (pool_ctl),
      .wr_key   (key_ff),
      .wr_value (value_ff),
      .rd       (pool_rd)
   );

   // bucket head and tail tables
   always_ff @(posedge clock) begin
      if (accept) begin
         head_rd_ff <= head_mem[chash_pkg::hash_bucket(req_key)];
         tail_rd_ff <= tail_mem[chash_pkg::hash_bucket(req_key)];
      end
   end

   always_ff @(posedge clock) begin
      if (bkt_we) begin
         tail_mem[bkt_ff] <= alloc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (bkt_we && !head_valid) begin
         head_mem[bkt_ff] <= alloc_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         chash_pkg::S_IDLE: begin
            if (req_valid) state_in = chash_pkg::S_HEAD;
         end
         chash_pkg::S_HEAD: begin
            if (cmd_ff == chash_pkg::CMD_INSERT) begin
               state_in = (!full && head_valid) ? chash_pkg::S_LINK : chash_pkg::S_DONE;
            end else begin
               state_in = head_valid ? chash_pkg::S_CMP : chash_pkg::S_DONE;
            end
         end
         chash_pkg::S_LINK: begin
            state_in = chash_pkg::S_DONE;
         end
         chash_pkg::S_CMP: begin
            if (key_match || !pool_rd.next_valid) state_in = chash_pkg::S_DONE;
         end
         chash_pkg::S_DONE: begin
            if (advance) state_in = chash_pkg::S_IDLE;
         end
         default: state_in = chash_pkg::S_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready           = 1'b0;
      bkt_we              = 1'b0;
      pool_ctl.entry_we   = 1'b0;
      pool_ctl.entry_addr = count_ff[chash_pkg::ENT_W-1:0];
      pool_ctl.link_we    = 1'b0;
      pool_ctl.link_addr  = count_ff[chash_pkg::ENT_W-1:0];
      pool_ctl.link_valid = 1'b0;
      pool_ctl.link_next  = '0;
      pool_ctl.rd_addr    = head_rd_ff;
      unique case (state_ff)
         chash_pkg::S_IDLE: begin
            req_ready = 1'b1;
         end
         chash_pkg::S_HEAD: begin
            if (cmd_ff == chash_pkg::CMD_INSERT && !full) begin
               // new entry starts as the end of its chain
               pool_ctl.entry_we = 1'b1;
               pool_ctl.link_we  = 1'b1;
               bkt_we            = 1'b1;
            end
         end
         chash_pkg::S_LINK: begin
            pool_ctl.link_we    = 1'b1;
            pool_ctl.link_addr  = tail_rd_ff;
            pool_ctl.link_valid = 1'b1;
            pool_ctl.link_next  = alloc_ff;
         end
         chash_pkg::S_CMP: begin
            pool_ctl.rd_addr = pool_rd.next;
         end
         chash_pkg::S_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // datapath
   always_comb begin
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      bkt_in        = bkt_ff;
      alloc_in      = alloc_ff;
      count_in      = count_ff;
      bvalid_in     = bvalid_ff;
      status_in     = status_ff;
      found_in      = found_ff;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      if (accept) begin
         cmd_in   = req_cmd;
         key_in   = req_key;
         value_in = req_value;
         bkt_in   = chash_pkg::hash_bucket(req_key);
      end

      if (state_ff == chash_pkg::S_HEAD) begin
         found_in = '0;
         alloc_in = count_ff[chash_pkg::ENT_W-1:0];
         if (cmd_ff == chash_pkg::CMD_INSERT) begin
            if (full) begin
               status_in = chash_pkg::STATUS_FULL;
            end else begin
               status_in         = chash_pkg::STATUS_OK;
               count_in          = count_ff + 1'b1;
               bvalid_in[bkt_ff] = 1'b1;
            end
         end else begin
            status_in = chash_pkg::STATUS_NOT_FOUND;
         end
      end

      if (state_ff == chash_pkg::S_CMP && key_match) begin
         status_in = chash_pkg::STATUS_OK;
         found_in  = pool_rd.value;
      end

      if (advance) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_found_in  = found_ff;
         rsp_count_in  = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= chash_pkg::S_IDLE;
         count_ff     <= '0;
         bvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         bvalid_ff    <= bvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      bkt_ff        <= bkt_in;
      alloc_ff      <= alloc_in;
      status_ff     <= status_in;
      found_ff      <= found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_value = rsp_found_ff;
   assign rsp_entry_count = rsp_count_ff;

   // the pool never overfills
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= chash_pkg::POOL_FULL)
      else $error("entry count beyond pool size");

   // a successful insert adds exactly one entry
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == chash_pkg::S_HEAD && cmd_ff == chash_pkg::CMD_INSERT && !full)
      |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("insert did not advance the entry count");

   // the count moves only while an insert is handled
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != chash_pkg::S_HEAD) |=> $stable(count_ff))
      else $error("entry count changed outside an insert");

   // a full answer only when the pool is exhausted
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (advance && status_ff == chash_pkg::STATUS_FULL) |-> full)
      else $error("pool full reported with free entries");

   // a pending word is never overwritten
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == chash_pkg::S_DONE && rsp_valid_ff && !rsp_ready)
      |=> (state_ff == chash_pkg::S_DONE))
      else $error("result word overwritten while stalled");

endmodule

// File: rtl/chash_pool.sv
// ----------------------------------------------------------------------------
// chash_pool
// Entry pool: key and value memory plus a separate link memory, so that a
// tail's next pointer can be rewritten without touching its key and value.
// ----------------------------------------------------------------------------
module chash_pool (
   input  logic                           clock,
   input  chash_pkg::pool_ctl_type        ctl,
   input  logic [chash_pkg::KEY_BITS-1:0] wr_key,
   input  logic [chash_pkg::VAL_BITS-1:0] wr_value,
   output chash_pkg::pool_rd_type         rd
);

   logic [chash_pkg::KEY_BITS-1:0] key_mem   [chash_pkg::ENTRIES];
   logic [chash_pkg::VAL_BITS-1:0] value_mem [chash_pkg::ENTRIES];
   logic [chash_pkg::ENT_W:0]      link_mem  [chash_pkg::ENTRIES];

   logic [chash_pkg::KEY_BITS-1:0] rd_key_ff;
   logic [chash_pkg::VAL_BITS-1:0] rd_value_ff;
   logic [chash_pkg::ENT_W:0]      rd_link_ff;

   always_ff @(posedge clock) begin
      if (ctl.entry_we) begin
         key_mem[ctl.entry_addr]   <= wr_key;
         value_mem[ctl.entry_addr] <= wr_value;
      end
      rd_key_ff   <= key_mem[ctl.rd_addr];
      rd_value_ff <= value_mem[ctl.rd_addr];
   end

   always_ff @(posedge clock) begin
      if (ctl.link_we) begin
         link_mem[ctl.link_addr] <= {ctl.link_valid, ctl.link_next};
      end
      rd_link_ff <= link_mem[ctl.rd_addr];
   end

   assign rd.key        = rd_key_ff;
   assign rd.value      = rd_value_ff;
   assign rd.next_valid = rd_link_ff[chash_pkg::ENT_W];
   assign rd.next       = rd_link_ff[chash_pkg::ENT_W-1:0];

endmodule
